>>> src/mlpt_pkg.sv
// Package for the multi-level page table: sizes, status codes,
// register indexes and reset values. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mlpt_pkg;
  localparam int ADDR_BITS        = 32;
  localparam int MAX_LEVELS       = 4;
  localparam int FRAME_BITS       = 20;
  localparam int DEF_POOL_ENTRIES = 65536;
  localparam int MAX_LEVEL_BITS   = 16;

  localparam logic [31:0] ADDR_MASK  = 32'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [19:0] FRAME_MASK = 20'((64'd1 << FRAME_BITS) - 64'd1);

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BAD_CFG = 2'd3;

  // command codes
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  // register indexes
  localparam logic [2:0] REG_LEVEL_COUNT = 3'd0;
  localparam logic [2:0] REG_LEVEL0_BITS = 3'd1;
  localparam logic [2:0] REG_LEVEL1_BITS = 3'd2;
  localparam logic [2:0] REG_LEVEL2_BITS = 3'd3;
  localparam logic [2:0] REG_LEVEL3_BITS = 3'd4;

  // register reset values
  localparam logic [2:0] RST_LEVEL_COUNT = 3'd2;
  localparam logic [4:0] RST_LEVEL0_BITS = 5'd10;
  localparam logic [4:0] RST_LEVEL1_BITS = 5'd10;
  localparam logic [4:0] RST_LEVEL2_BITS = 5'd4;
  localparam logic [4:0] RST_LEVEL3_BITS = 5'd4;

  typedef logic [4:0] level_bits_t;
endpackage
`default_nettype wire

>>> src/mlpt_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module mlpt_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write, and registered read of the same port (returns the old contents)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> src/multi_level_page_table.sv
// Top level of the multi-level page table: walk sequencer, allocator and
// configuration registers around one entry store RAM. Uses mlpt_pkg, mlpt_ram.
//
//  channel | direction | handshake         | payload
//  in      | input     | in_valid/in_stall | command, virtual_address, frame_number
//  out     | output    | out_valid/out_stall | status, frame_out, page_number, total_entries
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// An item is accepted, read and evaluated per level walked on the single RAM
// port, then its result is loaded; a miss or a full store ends the walk early,
// and a bad configuration goes straight to the result load. Reset and each
// write to register indexes 0 to 4 start a clearing pass over all POOL_ENTRIES
// entries of the entry store; no item is accepted during it. Register writes
// are taken only while no item is in flight, and hold off the input that cycle.
// A result waits in the output register; a new item may be accepted meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module multi_level_page_table #(
  parameter int POOL_ENTRIES = mlpt_pkg::DEF_POOL_ENTRIES,
  localparam int AW = $clog2(POOL_ENTRIES),
  localparam int PW = $clog2(POOL_ENTRIES + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic          command,
  input  wire logic [31:0]   virtual_address,
  input  wire logic [19:0]   frame_number,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         status,
  output logic [19:0]        frame_out,
  output logic [31:0]        page_number,
  output logic [PW-1:0]      total_entries,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [4:0]    cfg_data
);
  localparam int VW  = (mlpt_pkg::FRAME_BITS > AW) ? mlpt_pkg::FRAME_BITS : AW;
  localparam int EW  = VW + 1;
  localparam int SW  = ((PW > 17) ? PW : 17) + 1;
  localparam int QW  = ((AW > 16) ? AW : 16) + 1;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EV   = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]    state;
  logic [2:0]    level_count;
  mlpt_pkg::level_bits_t level_bits [4];
  logic [AW:0]   clr_cnt;
  logic [PW-1:0] alloc_ptr;
  logic          cmd;
  logic [31:0]   addr;
  logic [19:0]   frame;
  logic [1:0]    lvl;
  logic [AW-1:0] base;
  logic [AW-1:0] pos;
  logic [1:0]    res_status;
  logic [19:0]   res_frame;
  logic [31:0]   res_page;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;

  mlpt_ram #(.WIDTH(EW), .DEPTH(POOL_ENTRIES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // configuration checks
  logic       cfg_good;
  logic [6:0] bit_sum;
  logic [PW-1:0] root_size;
  always_comb begin
    cfg_good = 1'b1;
    bit_sum  = 7'd0;
    if (level_count == 3'd0 || 32'(level_count) > mlpt_pkg::MAX_LEVELS ||
        level_count > 3'd4) begin
      cfg_good = 1'b0;
    end
    for (int i = 0; i < 4; i++) begin
      if (i < int'(level_count)) begin
        if (level_bits[i] == 5'd0 || level_bits[i] > 5'(mlpt_pkg::MAX_LEVEL_BITS)) begin
          cfg_good = 1'b0;
        end
        bit_sum = bit_sum + 7'(level_bits[i]);
      end
    end
    if (32'(bit_sum) > mlpt_pkg::ADDR_BITS) cfg_good = 1'b0;
    if (level_bits[0] == 5'd0 || level_bits[0] > 5'(mlpt_pkg::MAX_LEVEL_BITS) ||
        (64'd1 << level_bits[0]) > 64'(POOL_ENTRIES)) begin
      root_size = '0;
    end else begin
      root_size = PW'(64'd1 << level_bits[0]);
    end
    if (root_size == '0) cfg_good = 1'b0;
  end

  // per-level index and position
  logic [6:0]  cum_bits;
  logic [15:0] idx;
  logic [QW-1:0] pos_sum;
  always_comb begin
    case (lvl)
      2'd0:    cum_bits = 7'(level_bits[0]);
      2'd1:    cum_bits = 7'(level_bits[0]) + 7'(level_bits[1]);
      2'd2:    cum_bits = 7'(level_bits[0]) + 7'(level_bits[1]) + 7'(level_bits[2]);
      default: cum_bits = 7'(level_bits[0]) + 7'(level_bits[1]) + 7'(level_bits[2])
                          + 7'(level_bits[3]);
    endcase
    idx = 16'((addr >> (7'(mlpt_pkg::ADDR_BITS) - cum_bits)) &
              ((32'd1 << level_bits[lvl]) - 32'd1));
    pos_sum = QW'(base) + QW'(idx);
  end

  // allocation of the next level's node
  logic [SW-1:0] alloc_end;
  logic          is_leaf;
  logic          entry_valid;
  logic          out_free;
  logic          out_load;
  logic          cfg_write;
  assign alloc_end   = SW'(alloc_ptr) + (SW'(1) << level_bits[lvl + 2'd1]);
  assign is_leaf     = (3'(lvl) + 3'd1) == level_count;
  assign entry_valid = ram_rdata[EW-1];
  assign out_free    = !out_valid || !out_stall;
  assign out_load    = (state == S_FIN) && out_free;

  // register writes only between items; input held off during a write
  assign cfg_ready = (state == S_CLR) || (state == S_IDLE);
  assign cfg_write = cfg_valid && cfg_ready;
  assign in_stall  = (state != S_IDLE) || cfg_valid;

  // RAM port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = pos;
    ram_wdata = '0;
    case (state)
      S_CLR: begin
        ram_we   = 1'b1;
        ram_addr = clr_cnt[AW-1:0];
      end
      S_RD: begin
        ram_addr = pos_sum[AW-1:0];
      end
      S_EV: begin
        if (is_leaf) begin
          ram_we    = (cmd == mlpt_pkg::CMD_INSERT);
          ram_wdata = {1'b1, VW'(frame)};
        end else if (!entry_valid && cmd == mlpt_pkg::CMD_INSERT &&
                     alloc_end <= SW'(POOL_ENTRIES)) begin
          ram_we    = 1'b1;
          ram_wdata = {1'b1, VW'(alloc_ptr)};
        end
      end
      default: ;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      level_count   <= mlpt_pkg::RST_LEVEL_COUNT;
      level_bits[0] <= mlpt_pkg::RST_LEVEL0_BITS;
      level_bits[1] <= mlpt_pkg::RST_LEVEL1_BITS;
      level_bits[2] <= mlpt_pkg::RST_LEVEL2_BITS;
      level_bits[3] <= mlpt_pkg::RST_LEVEL3_BITS;
    end else if (cfg_write) begin
      if (cfg_index == mlpt_pkg::REG_LEVEL_COUNT) begin
        level_count <= cfg_data[2:0];
      end else if (cfg_index <= mlpt_pkg::REG_LEVEL3_BITS) begin
        level_bits[2'(cfg_index - mlpt_pkg::REG_LEVEL0_BITS)] <= cfg_data;
      end
    end
  end

  // output valid: set on a result load, cleared when the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // walk sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
    end else begin
      if (cfg_write && cfg_index <= mlpt_pkg::REG_LEVEL3_BITS) begin
        state   <= S_CLR;
        clr_cnt <= '0;
      end else begin
        case (state)
          S_CLR: begin
            clr_cnt   <= clr_cnt + 1'b1;
            alloc_ptr <= root_size;
            if (clr_cnt == (AW + 1)'(POOL_ENTRIES - 1)) state <= S_IDLE;
          end
          S_IDLE: begin
            if (in_valid && !in_stall) begin
              cmd   <= command;
              addr  <= virtual_address & mlpt_pkg::ADDR_MASK;
              frame <= frame_number & mlpt_pkg::FRAME_MASK;
              lvl   <= 2'd0;
              base  <= '0;
              res_frame <= '0;
              if (!cfg_good) begin
                res_status <= mlpt_pkg::ST_BAD_CFG;
                res_page   <= '0;
                state      <= S_FIN;
              end else begin
                res_status <= mlpt_pkg::ST_OK;
                res_page   <= (virtual_address & mlpt_pkg::ADDR_MASK) >>
                              (7'(mlpt_pkg::ADDR_BITS) - bit_sum);
                state      <= S_RD;
              end
            end
          end
          S_RD: begin
            pos <= pos_sum[AW-1:0];
            if (pos_sum >= QW'(POOL_ENTRIES)) begin
              res_status <= cmd ? mlpt_pkg::ST_FULL : mlpt_pkg::ST_MISS;
              state      <= S_FIN;
            end else begin
              state <= S_EV;
            end
          end
          S_EV: begin
            if (is_leaf) begin
              if (cmd == mlpt_pkg::CMD_INSERT) begin
                res_frame <= frame;
              end else if (entry_valid) begin
                res_frame <= 20'(ram_rdata[VW-1:0]) & mlpt_pkg::FRAME_MASK;
              end else begin
                res_status <= mlpt_pkg::ST_MISS;
              end
              state <= S_FIN;
            end else if (entry_valid) begin
              base  <= ram_rdata[AW-1:0];
              lvl   <= lvl + 2'd1;
              state <= S_RD;
            end else if (cmd == mlpt_pkg::CMD_LOOKUP) begin
              res_status <= mlpt_pkg::ST_MISS;
              state      <= S_FIN;
            end else if (alloc_end > SW'(POOL_ENTRIES)) begin
              res_status <= mlpt_pkg::ST_FULL;
              state      <= S_FIN;
            end else begin
              base      <= alloc_ptr[AW-1:0];
              alloc_ptr <= PW'(alloc_end);
              lvl       <= lvl + 2'd1;
              state     <= S_RD;
            end
          end
          S_FIN: begin
            if (out_free) begin
              status        <= res_status;
              frame_out     <= (res_status == mlpt_pkg::ST_OK) ? res_frame : 20'd0;
              page_number   <= res_page;
              total_entries <= alloc_ptr;
              state         <= S_IDLE;
            end
          end
          default: state <= S_CLR;
        endcase
      end
    end
  end
endmodule
`default_nettype wire

>>> tb/sv/tb_multi_level_page_table.sv
// Self-checking testbench for multi_level_page_table: directed table, then
// random lookup/insert traffic over several level layouts. Uses mlpt_pkg.
`timescale 1ns / 1ps
module tb_multi_level_page_table;
  localparam int POOL        = mlpt_pkg::DEF_POOL_ENTRIES;
  localparam int IDLE_LIMIT  = 200000;
  localparam logic [2:0] REG_UNUSED      = 3'd7;

  typedef struct packed {
    logic [1:0]  st;
    logic [19:0] fr;
    logic [31:0] pn;
    logic [16:0] te;
  } xlate_t;

  typedef struct {
    logic        cmd;
    logic [31:0] addr;
    logic [19:0] frame;
    bit          typed;
    logic [1:0]  st;
    logic [19:0] fr;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = 1'b0;
  logic [31:0] virtual_address = '0;
  logic [19:0] frame_number = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [19:0] frame_out;
  logic [31:0] page_number;
  logic [16:0] total_entries;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [4:0]  cfg_data = '0;

  // typed expectation riding along with the current input transfer
  bit          cur_typed = 1'b0;
  logic [1:0]  cur_st = '0;
  logic [19:0] cur_fr = '0;

  bit quiet = 1'b0;
  int errors = 0;
  int idle_cycles = 0;
  xlate_t pending_xlates[$];
  logic [31:0] mapped_addrs[$];

  // shadow page table
  int unsigned lvl_count;
  int unsigned lvl_bits[4];
  bit          slot_valid[POOL];
  int unsigned slot_value[POOL];
  int unsigned next_free;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multi_level_page_table u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .virtual_address(virtual_address), .frame_number(frame_number),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .frame_out(frame_out), .page_number(page_number),
    .total_entries(total_entries),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic int unsigned root_entries();
    if (lvl_bits[0] == 0 || lvl_bits[0] > mlpt_pkg::MAX_LEVEL_BITS) return 0;
    if ((1 << lvl_bits[0]) > POOL) return 0;
    return 1 << lvl_bits[0];
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < POOL; i++) begin
      slot_valid[i] = 1'b0;
      slot_value[i] = 0;
    end
    next_free = root_entries();
  endfunction

  function automatic void write_register(logic [2:0] idx, logic [4:0] data);
    if (idx == mlpt_pkg::REG_LEVEL_COUNT) lvl_count = data[2:0];
    else if (idx <= mlpt_pkg::REG_LEVEL3_BITS) lvl_bits[idx - 1] = data;
    else return;
    clear_table();
  endfunction

  // one table walk; updates the shadow table on insert
  function automatic xlate_t walk_table(logic cmd, logic [31:0] addr, logic [19:0] frame);
    xlate_t r;
    int unsigned sum, shift, base, idx, pos, sz;
    bit ok;
    r = '0;
    r.te = next_free[16:0];
    ok = (lvl_count >= 1 && lvl_count <= mlpt_pkg::MAX_LEVELS);
    sum = 0;
    if (ok)
      for (int i = 0; i < lvl_count; i++) begin
        if (lvl_bits[i] == 0 || lvl_bits[i] > mlpt_pkg::MAX_LEVEL_BITS) ok = 0;
        sum += lvl_bits[i];
      end
    if (!ok || sum > mlpt_pkg::ADDR_BITS || root_entries() == 0) begin
      r.st = mlpt_pkg::ST_BAD_CFG;
      return r;
    end
    r.pn = addr >> (mlpt_pkg::ADDR_BITS - sum);
    r.st = mlpt_pkg::ST_OK;
    shift = mlpt_pkg::ADDR_BITS;
    base = 0;
    for (int i = 0; i < lvl_count; i++) begin
      shift -= lvl_bits[i];
      idx = (addr >> shift) & ((1 << lvl_bits[i]) - 1);
      pos = base + idx;
      if (pos >= POOL) begin
        r.st = cmd ? mlpt_pkg::ST_FULL : mlpt_pkg::ST_MISS;
        break;
      end
      if (i + 1 == lvl_count) begin
        if (cmd == mlpt_pkg::CMD_INSERT) begin
          slot_valid[pos] = 1'b1;
          slot_value[pos] = frame;
          r.fr = frame;
        end else if (slot_valid[pos]) r.fr = slot_value[pos][19:0];
        else r.st = mlpt_pkg::ST_MISS;
        break;
      end
      if (!slot_valid[pos]) begin
        if (cmd == mlpt_pkg::CMD_LOOKUP) begin
          r.st = mlpt_pkg::ST_MISS;
          break;
        end
        sz = 1 << lvl_bits[i + 1];
        if (next_free + sz > POOL) begin
          r.st = mlpt_pkg::ST_FULL;
          break;
        end
        slot_valid[pos] = 1'b1;
        slot_value[pos] = next_free;
        next_free += sz;
      end
      base = slot_value[pos];
    end
    if (r.st != mlpt_pkg::ST_OK) r.fr = '0;
    r.te = next_free[16:0];
    return r;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // transfer monitor: check results, predict accepted items, track config
  always @(posedge clk) begin
    xlate_t want;
    bit moved;
    if (!rst) begin
      moved = 1'b0;
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (pending_xlates.size() == 0) flag_mismatch("unexpected result", status, 0);
        else begin
          want = pending_xlates.pop_front();
          if (status !== want.st) flag_mismatch("status", status, want.st);
          if (frame_out !== want.fr) flag_mismatch("frame_out", frame_out, want.fr);
          if (page_number !== want.pn) flag_mismatch("page_number", page_number, want.pn);
          if (total_entries !== want.te) flag_mismatch("total_entries", total_entries, want.te);
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        want = walk_table(command, virtual_address, frame_number);
        if (cur_typed) begin
          want.st = cur_st;
          want.fr = cur_fr;
        end
        pending_xlates.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        moved = 1'b1;
        write_register(cfg_index, cfg_data);
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_multi_level_page_table NOT OK");
        $finish;
      end
    end
  end

  // receiver stall in random bursts
  initial begin
    int left;
    left = 0;
    forever begin
      @(posedge clk);
      if (quiet) out_stall <= 1'b0;
      else if (left == 0) begin
        left = $urandom_range(1, 10);
        out_stall <= ($urandom_range(0, 2) == 0);
      end else left--;
    end
  end

  task automatic send_item(logic cmd, logic [31:0] addr, logic [19:0] frame,
                           bit typed, logic [1:0] st, logic [19:0] fr);
    if (!quiet && $urandom_range(0, 3) == 0 && in_valid) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    virtual_address <= addr;
    frame_number <= frame;
    cur_typed <= typed;
    cur_st <= st;
    cur_fr <= fr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == mlpt_pkg::CMD_INSERT) mapped_addrs.push_back(addr);
  endtask

  task automatic drain();
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    while (pending_xlates.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_register(logic [2:0] idx, logic [4:0] data);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random traffic: mostly lookups/updates of known pages
  task automatic random_items(int n);
    logic [31:0] a;
    for (int k = 0; k < n; k++) begin
      if (mapped_addrs.size() != 0 && $urandom_range(0, 9) < 6) begin
        a = mapped_addrs[$urandom_range(0, mapped_addrs.size() - 1)];
        a = a ^ ($urandom() & 32'h0000_0fff);
      end else a = $urandom();
      send_item(1'($urandom_range(0, 1)), a, 20'($urandom()), 1'b0, '0, '0);
    end
  endtask

  // reset layout: two levels of 10 bits, 12 offset bits
  dir_row_t dir_rows [16] = '{
    '{mlpt_pkg::CMD_LOOKUP, 32'h0000_0000, 20'h00000, 1, mlpt_pkg::ST_MISS, 20'h00000},
    '{mlpt_pkg::CMD_INSERT, 32'h0000_0000, 20'h00000, 1, mlpt_pkg::ST_OK,   20'h00000},
    '{mlpt_pkg::CMD_LOOKUP, 32'h0000_0fff, 20'hfffff, 1, mlpt_pkg::ST_OK,   20'h00000},
    '{mlpt_pkg::CMD_INSERT, 32'hffff_ffff, 20'hfffff, 1, mlpt_pkg::ST_OK,   20'hfffff},
    '{mlpt_pkg::CMD_LOOKUP, 32'hffff_f000, 20'h00000, 1, mlpt_pkg::ST_OK,   20'hfffff},
    '{mlpt_pkg::CMD_INSERT, 32'h0000_0000, 20'h12345, 1, mlpt_pkg::ST_OK,   20'h12345},
    '{mlpt_pkg::CMD_LOOKUP, 32'h0000_0123, 20'h00000, 1, mlpt_pkg::ST_OK,   20'h12345},
    '{mlpt_pkg::CMD_LOOKUP, 32'h0040_0000, 20'h00000, 1, mlpt_pkg::ST_MISS, 20'h00000},
    '{mlpt_pkg::CMD_LOOKUP, 32'h0000_1000, 20'h00000, 1, mlpt_pkg::ST_MISS, 20'h00000},
    '{mlpt_pkg::CMD_INSERT, 32'h8000_0000, 20'h80000, 0, mlpt_pkg::ST_OK,   20'h00000},
    '{mlpt_pkg::CMD_INSERT, 32'h7fff_ffff, 20'h7ffff, 0, mlpt_pkg::ST_OK,   20'h00000},
    '{mlpt_pkg::CMD_LOOKUP, 32'h8000_0abc, 20'h00000, 0, mlpt_pkg::ST_OK,   20'h00000},
    '{mlpt_pkg::CMD_LOOKUP, 32'h7fff_f000, 20'h00000, 0, mlpt_pkg::ST_OK,   20'h00000},
    '{mlpt_pkg::CMD_INSERT, 32'h5555_5555, 20'haaaaa, 0, mlpt_pkg::ST_OK,   20'h00000},
    '{mlpt_pkg::CMD_LOOKUP, 32'haaaa_aaaa, 20'h55555, 0, mlpt_pkg::ST_OK,   20'h00000},
    '{mlpt_pkg::CMD_LOOKUP, 32'h5555_5000, 20'h00000, 0, mlpt_pkg::ST_OK,   20'h00000}
  };

  initial begin
    lvl_count = mlpt_pkg::RST_LEVEL_COUNT;
    lvl_bits[0] = mlpt_pkg::RST_LEVEL0_BITS;
    lvl_bits[1] = mlpt_pkg::RST_LEVEL1_BITS;
    lvl_bits[2] = mlpt_pkg::RST_LEVEL2_BITS;
    lvl_bits[3] = mlpt_pkg::RST_LEVEL3_BITS;
    clear_table();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i])
      send_item(dir_rows[i].cmd, dir_rows[i].addr, dir_rows[i].frame,
                dir_rows[i].typed, dir_rows[i].st, dir_rows[i].fr);
    random_items(40);

    set_register(mlpt_pkg::REG_LEVEL_COUNT, 5'd4);    // 10/10/4/4
    random_items(90);
    set_register(mlpt_pkg::REG_LEVEL0_BITS, 5'd16);   // 34 bits: bad layout
    send_item(mlpt_pkg::CMD_INSERT, 32'hdead_beef, 20'h1, 1, mlpt_pkg::ST_BAD_CFG, 20'h0);
    random_items(5);
    set_register(mlpt_pkg::REG_LEVEL3_BITS, 5'd1);    // 16/10/4/1
    random_items(50);
    set_register(mlpt_pkg::REG_LEVEL2_BITS, 5'd1);    // 16/10/1/1
    random_items(50);
    set_register(mlpt_pkg::REG_LEVEL1_BITS, 5'd1);    // 16/1/1/1
    random_items(50);
    set_register(mlpt_pkg::REG_LEVEL_COUNT, 5'd1);    // single 16-bit level
    random_items(30);
    set_register(mlpt_pkg::REG_LEVEL_COUNT, 5'd7);    // too many levels
    random_items(5);
    set_register(REG_UNUSED, 5'd31);                  // ignored index, table kept
    set_register(mlpt_pkg::REG_LEVEL1_BITS, 5'd16);
    set_register(mlpt_pkg::REG_LEVEL_COUNT, 5'd2);    // 16/16: root fills the store
    send_item(mlpt_pkg::CMD_INSERT, 32'h0001_0002, 20'h3, 1, mlpt_pkg::ST_FULL, 20'h0);
    random_items(30);
    set_register(mlpt_pkg::REG_LEVEL_COUNT, 5'd0);    // no levels
    quiet = 1'b1;
    random_items(30);

    drain();
    if (errors == 0) $display("tb_multi_level_page_table OK");
    else $display("tb_multi_level_page_table NOT OK");
    $finish;
  end
endmodule
